// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL. Each one samples on clk and is
// switched off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every sampled edge.
`define BPCR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define BPCR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/bpcr_pkg.sv -----
`default_nettype none

package bpcr_pkg;

	// Default width of the hold timer; the counter itself is one bit wider.
	localparam int TIMER_BITS_DEF = 16;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [7:0]  POLL_STEP_RST       = 8'd50;
	localparam logic [15:0] REPEAT_INTERVAL_RST = 16'd1;

	typedef enum logic [1:0] {
		REG_LONG_PRESS_TIME = 2'd0,
		REG_POLL_STEP       = 2'd1,
		REG_REPEAT_TOTAL    = 2'd2,
		REG_REPEAT_INTERVAL = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_SHORT  = 2'd0,
		KIND_LONG   = 2'd1,
		KIND_REPEAT = 2'd2
	} kind_t;

endpackage

`default_nettype wire

// ----- rtl/button_press_classifier_repeat_core.sv -----
`default_nettype none

// Button press classifier with long-press auto-repeat. Each item on the button
// channel is one millisecond tick carrying the sampled level; each item on the
// event channel is a short press, a long press or a periodic repeat, and a tick
// gives at most one event. One item is taken every clock cycle unless the button
// side stalls: the tick is captured in an input register, classified by the
// logic that follows it and written to the event register when it advances.
// The button side stalls only while a finished event is held in the event
// register by a stalled receiver.
// Registers: 0x0 long_press_time (0 makes every press short), 0x4 poll_step
// (reset 50), 0x8 repeat_total (0 starts no new repeat sequence), 0xC repeat_interval
// (reset 1). They must be written only while no tick is in flight; the block does not enforce it.
module button_press_classifier_repeat_core #(
	parameter int TIMER_BITS = bpcr_pkg::TIMER_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [bpcr_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [bpcr_pkg::PDATA_W-1:0]  pwdata,
	output logic      [bpcr_pkg::PDATA_W-1:0]  prdata,
	output logic                               pready,
	input  wire logic                          button_valid,
	output logic                               button_stall,
	input  wire logic                          button_level,
	output logic                               event_valid,
	input  wire logic                          event_stall,
	output logic      [1:0]                    event_kind,
	output logic      [15:0]                   repeats_left,
	output logic                               restarted
);
	import bpcr_pkg::*;

	localparam int HOLD_W = TIMER_BITS + 1;
	localparam int CMP_W  = (HOLD_W > 16) ? HOLD_W : 16;
	localparam logic [HOLD_W-1:0] HOLD_SAT = {HOLD_W{1'b1}};

	// Configuration registers
	logic [15:0] long_press_time_q;
	logic [7:0]  poll_step_q;
	logic [15:0] repeat_total_q;
	logic [15:0] repeat_interval_q;

	// Input stage
	logic valid_s1;
	logic level_s1;

	// Classifier state
	logic              last_level_q;
	logic              holding_q;
	logic [HOLD_W-1:0] hold_elapsed_q;
	logic [7:0]        poll_phase_q;
	logic [15:0]       repeat_left_q;
	logic [15:0]       countdown_q;

	// Event register
	logic        out_valid_q;
	kind_t       kind_q;
	logic [15:0] left_q;
	logic        restarted_q;

	logic cfg_wr;
	logic advance;

	// Next-state values of the classifier
	logic [15:0]       iload;
	logic [15:0]       cd_dec;
	logic              due;
	logic [15:0]       rep_mid;
	logic [15:0]       cd_mid;
	logic [7:0]        step;
	logic [7:0]        phase_inc;
	logic [HOLD_W-1:0] hold_inc;
	logic              reached;
	logic              dec_short;
	logic              dec_long;
	logic              holding_d;
	logic [HOLD_W-1:0] hold_d;
	logic [7:0]        phase_d;
	logic [15:0]       rep_d;
	logic [15:0]       cd_d;
	logic              has_res;
	kind_t             kind_d;
	logic              rst_d;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		case (reg_idx_t'(paddr[3:2]))
			REG_LONG_PRESS_TIME: prdata = {16'd0, long_press_time_q};
			REG_POLL_STEP:       prdata = {24'd0, poll_step_q};
			REG_REPEAT_TOTAL:    prdata = {16'd0, repeat_total_q};
			REG_REPEAT_INTERVAL: prdata = {16'd0, repeat_interval_q};
			default:             prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_time_q <= '0;
			poll_step_q       <= POLL_STEP_RST;
			repeat_total_q    <= '0;
			repeat_interval_q <= REPEAT_INTERVAL_RST;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[3:2]))
				REG_LONG_PRESS_TIME: long_press_time_q <= pwdata[15:0];
				REG_POLL_STEP:       poll_step_q       <= pwdata[7:0];
				REG_REPEAT_TOTAL:    repeat_total_q    <= pwdata[15:0];
				REG_REPEAT_INTERVAL: repeat_interval_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// A tick in the input register moves on unless the event register is
	// full and its receiver is stalling.
	assign button_stall = valid_s1 && out_valid_q && event_stall;
	assign advance      = valid_s1 && !button_stall;

	always_comb begin
		iload = (repeat_interval_q == '0) ? 16'd1 : repeat_interval_q;

		// Repeat timer
		due     = 1'b0;
		rep_mid = repeat_left_q;
		cd_mid  = countdown_q;
		cd_dec  = (countdown_q != '0) ? 16'(countdown_q - 16'd1) : countdown_q;
		if (repeat_left_q != '0) begin
			cd_mid = cd_dec;
			if (cd_dec == '0) begin
				due     = 1'b1;
				rep_mid = 16'(repeat_left_q - 16'd1);
				if (rep_mid != '0) begin
					cd_mid = iload;
				end
			end
		end

		// Press detection
		step      = (poll_step_q == '0) ? 8'd1 : poll_step_q;
		phase_inc = 8'(poll_phase_q + 8'd1);
		hold_inc  = (hold_elapsed_q != HOLD_SAT) ?
			HOLD_W'(hold_elapsed_q + 1'b1) : hold_elapsed_q;
		reached   = (CMP_W'(hold_inc) >= CMP_W'(long_press_time_q)) || (hold_inc == HOLD_SAT);

		dec_short = 1'b0;
		dec_long  = 1'b0;
		holding_d = holding_q;
		hold_d    = hold_elapsed_q;
		phase_d   = poll_phase_q;
		if (!holding_q) begin
			if (level_s1 && !last_level_q) begin
				if (long_press_time_q == '0) begin
					dec_short = 1'b1;
				end else begin
					holding_d = 1'b1;
					hold_d    = '0;
					phase_d   = '0;
				end
			end
		end else begin
			hold_d  = hold_inc;
			phase_d = phase_inc;
			if (phase_inc >= step) begin
				phase_d = '0;
				if (long_press_time_q == '0) begin
					dec_short = 1'b1;
				end else if (reached) begin
					dec_long  = level_s1;
					dec_short = !level_s1;
				end else if (!level_s1) begin
					dec_short = 1'b1;
				end
			end
			if (dec_short || dec_long) begin
				holding_d = 1'b0;
				hold_d    = '0;
				phase_d   = '0;
			end
		end

		// A decision takes precedence over a repeat due on the same tick.
		rep_d   = rep_mid;
		cd_d    = cd_mid;
		rst_d   = 1'b0;
		kind_d  = KIND_REPEAT;
		has_res = due;
		if (dec_long) begin
			has_res = 1'b1;
			kind_d  = KIND_LONG;
			rst_d   = (repeat_total_q != '0) && (rep_mid != '0);
			if (repeat_total_q > 16'd1) begin
				rep_d = 16'(repeat_total_q - 16'd1);
				cd_d  = iload;
			end else if (repeat_total_q == 16'd1) begin
				rep_d = '0;
				cd_d  = '0;
			end
		end else if (dec_short) begin
			has_res = 1'b1;
			kind_d  = KIND_SHORT;
			if (repeat_total_q != '0 && rep_mid != '0) begin
				rep_d = '0;
				cd_d  = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			last_level_q   <= 1'b0;
			holding_q      <= 1'b0;
			hold_elapsed_q <= '0;
			poll_phase_q   <= '0;
			repeat_left_q  <= '0;
			countdown_q    <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (!button_stall) begin
				valid_s1 <= button_valid;
			end
			if (advance) begin
				last_level_q   <= level_s1;
				holding_q      <= holding_d;
				hold_elapsed_q <= hold_d;
				poll_phase_q   <= phase_d;
				repeat_left_q  <= rep_d;
				countdown_q    <= cd_d;
			end
			if (advance && has_res) begin
				out_valid_q <= 1'b1;
			end else if (!event_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (button_valid && !button_stall) begin
			level_s1 <= button_level;
		end
		if (advance && has_res) begin
			kind_q      <= kind_d;
			left_q      <= rep_d;
			restarted_q <= rst_d;
		end
	end

	assign event_valid  = out_valid_q;
	assign event_kind   = kind_q;
	assign repeats_left = left_q;
	assign restarted    = restarted_q;

	`include "assert_macros.svh"

	`BPCR_ASSERT(a_restart_long, !(out_valid_q && restarted_q) || (kind_q == KIND_LONG), "restart flag on an event that is not a long press")
	`BPCR_ASSERT(a_idle_timer, (repeat_left_q != '0) || (countdown_q == '0), "repeat timer running with no sequence")
	`BPCR_ASSERT(a_idle_hold, holding_q || (hold_elapsed_q == '0 && poll_phase_q == '0), "hold counters not cleared outside a hold")
	`BPCR_ASSERT(a_stall_cause, !button_stall || (out_valid_q && event_stall), "button side stalled with room for an event")
	`BPCR_ASSERT_NEXT(a_stalled_event_kept, out_valid_q && event_stall, out_valid_q, "stalled event dropped")

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`default_nettype none

module tb;
	import bpcr_pkg::*;

	localparam int HOLD_W = TIMER_BITS_DEF + 1;
	localparam logic [HOLD_W-1:0] HOLD_MAX = '1;
	localparam int QUIET_LIMIT = 500;
	localparam int MAX_PRINTED = 40;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] left;
		logic        restarted;
	} press_event_t;

	typedef enum {VERDICT_NONE, VERDICT_SHORT, VERDICT_LONG} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;
	logic button_valid = 1'b0;
	logic button_stall;
	logic button_level = 1'b0;
	logic event_valid;
	logic event_stall = 1'b0;
	logic [1:0] event_kind;
	logic [15:0] repeats_left;
	logic restarted;

	// Register copies and classifier state, as after reset.
	logic [15:0] cfg_lpt = 16'd0;
	logic [7:0] cfg_poll = POLL_STEP_RST;
	logic [15:0] cfg_total = 16'd0;
	logic [15:0] cfg_interval = REPEAT_INTERVAL_RST;
	logic prev_level = 1'b0;
	logic in_hold = 1'b0;
	logic [HOLD_W-1:0] held_ticks = '0;
	logic [7:0] phase = 8'd0;
	logic [15:0] seq_left = 16'd0;
	logic [15:0] countdown = 16'd0;

	press_event_t expected_events[$];
	int err_count = 0;
	int ticks_sent = 0;
	int stall_hold = 0;
	int quiet_cycles = 0;
	bit no_idle = 1'b0;

	button_press_classifier_repeat_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.button_valid(button_valid),
		.button_stall(button_stall),
		.button_level(button_level),
		.event_valid(event_valid),
		.event_stall(event_stall),
		.event_kind(event_kind),
		.repeats_left(repeats_left),
		.restarted(restarted)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (err_count < MAX_PRINTED)
			$display("%0t mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
		err_count++;
	endtask

	// Works out the event, if any, that one tick of the button level causes.
	function automatic void classify_tick(input logic lvl);
		verdict_t verdict;
		bit due;
		logic [7:0] step;
		logic [15:0] reload;
		press_event_t ev;
		verdict = VERDICT_NONE;
		due = 1'b0;
		step = (cfg_poll == 8'd0) ? 8'd1 : cfg_poll;
		reload = (cfg_interval == 16'd0) ? 16'd1 : cfg_interval;
		if (seq_left != 16'd0) begin
			if (countdown != 16'd0)
				countdown--;
			if (countdown == 16'd0) begin
				due = 1'b1;
				seq_left--;
				if (seq_left != 16'd0)
					countdown = reload;
			end
		end
		if (!in_hold) begin
			if (lvl && !prev_level) begin
				if (cfg_lpt == 16'd0) begin
					verdict = VERDICT_SHORT;
				end else begin
					in_hold = 1'b1;
					held_ticks = '0;
					phase = 8'd0;
				end
			end
		end else begin
			if (held_ticks != HOLD_MAX)
				held_ticks++;
			phase++;
			if (phase >= step) begin
				phase = 8'd0;
				if (cfg_lpt == 16'd0)
					verdict = VERDICT_SHORT;
				else if (held_ticks >= cfg_lpt || held_ticks == HOLD_MAX)
					verdict = lvl ? VERDICT_LONG : VERDICT_SHORT;
				else if (!lvl)
					verdict = VERDICT_SHORT;
			end
			if (verdict != VERDICT_NONE) begin
				in_hold = 1'b0;
				held_ticks = '0;
				phase = 8'd0;
			end
		end
		prev_level = lvl;
		case (verdict)
			VERDICT_LONG: begin
				ev.restarted = (cfg_total != 16'd0 && seq_left != 16'd0);
				if (cfg_total > 16'd1) begin
					seq_left = cfg_total - 16'd1;
					countdown = reload;
				end else if (cfg_total == 16'd1) begin
					seq_left = 16'd0;
					countdown = 16'd0;
				end
				ev.kind = KIND_LONG;
				ev.left = seq_left;
				expected_events.push_back(ev);
			end
			VERDICT_SHORT: begin
				if (cfg_total != 16'd0 && seq_left != 16'd0) begin
					seq_left = 16'd0;
					countdown = 16'd0;
				end
				ev.kind = KIND_SHORT;
				ev.left = seq_left;
				ev.restarted = 1'b0;
				expected_events.push_back(ev);
			end
			default: begin
				if (due) begin
					ev.kind = KIND_REPEAT;
					ev.left = seq_left;
					ev.restarted = 1'b0;
					expected_events.push_back(ev);
				end
			end
		endcase
	endfunction

	// Results are checked before the tick of the same edge is predicted; a tick
	// cannot produce its event at the edge at which it is taken.
	always @(posedge clk) begin
		press_event_t want;
		if (arst_n) begin
			if (event_valid && !event_stall) begin
				stall_hold = no_idle ? 0 : $urandom_range(0, 3);
				if (expected_events.size() == 0) begin
					report_mismatch("unexpected event, kind", event_kind, -1);
				end else begin
					want = expected_events.pop_front();
					if (event_kind !== want.kind)
						report_mismatch("event_kind", event_kind, want.kind);
					if (repeats_left !== want.left)
						report_mismatch("repeats_left", repeats_left, want.left);
					if (restarted !== want.restarted)
						report_mismatch("restarted", restarted, want.restarted);
				end
			end
			if (button_valid && !button_stall)
				classify_tick(button_level);
		end
	end

	always @(negedge clk) begin
		if (stall_hold != 0) begin
			event_stall <= 1'b1;
			stall_hold--;
		end else begin
			event_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (button_valid && !button_stall) || (event_valid && !event_stall)
				|| (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_tick(input logic lvl);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		@(negedge clk);
		if (gap != 0) begin
			button_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		button_valid <= 1'b1;
		button_level <= lvl;
		do @(posedge clk); while (button_stall);
		ticks_sent++;
	endtask

	task automatic send_run(input logic lvl, input int count);
		repeat (count) send_tick(lvl);
	endtask

	// Lets every tick in flight finish, including ticks that give no event.
	task automatic drain();
		@(negedge clk);
		button_valid <= 1'b0;
		while (expected_events.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes one register, then reads it back in the following transfer.
	task automatic set_reg(input reg_idx_t idx, input logic [31:0] value);
		logic [31:0] mask;
		mask = (idx == REG_POLL_STEP) ? 32'h0000_00FF : 32'h0000_FFFF;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_LONG_PRESS_TIME: cfg_lpt = value[15:0];
			REG_POLL_STEP:       cfg_poll = value[7:0];
			REG_REPEAT_TOTAL:    cfg_total = value[15:0];
			default:             cfg_interval = value[15:0];
		endcase
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if ((prdata & mask) !== (value & mask))
			report_mismatch("register read-back", prdata, value & mask);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic configure(input int lpt, input int poll, input int total, input int interval);
		drain();
		set_reg(REG_LONG_PRESS_TIME, lpt);
		set_reg(REG_POLL_STEP, poll);
		set_reg(REG_REPEAT_TOTAL, total);
		set_reg(REG_REPEAT_INTERVAL, interval);
	endtask

	// With the reset settings the long-press time is 0, so each press is short.
	task automatic test_reset_defaults();
		send_run(1'b1, 1);
		send_run(1'b0, 1);
		send_run(1'b1, 2);
		send_run(1'b0, 1);
	endtask

	// Long press, a repeat, a restart, then a short press that lands on a due
	// repeat and cancels the sequence.
	task automatic test_long_and_repeat();
		configure(2, 1, 3, 3);
		send_run(1'b1, 3);
		send_run(1'b0, 1);
		send_run(1'b1, 3);
		send_run(1'b0, 1);
		send_run(1'b1, 1);
		send_run(1'b0, 1);
	endtask

	task automatic test_repeat_totals();
		configure(2, 1, 5, 4);
		send_run(1'b1, 3);
		send_run(1'b0, 1);
		drain();
		// A total of 0 leaves the running sequence alone on short and long presses.
		set_reg(REG_REPEAT_TOTAL, 0);
		send_run(1'b1, 1);
		send_run(1'b0, 1);
		send_run(1'b1, 3);
		send_run(1'b0, 1);
		drain();
		// A total of 1 cancels it on a long press.
		set_reg(REG_REPEAT_TOTAL, 1);
		send_run(1'b1, 3);
		send_run(1'b0, 1);
	endtask

	task automatic test_special_cases();
		// Poll step and interval of 0 behave as 1.
		configure(3, 0, 3, 0);
		send_run(1'b1, 4);
		send_run(1'b0, 3);
		// Long-press time cleared in the middle of a hold.
		configure(10, 2, 0, 1);
		send_run(1'b1, 2);
		drain();
		set_reg(REG_LONG_PRESS_TIME, 0);
		send_run(1'b1, 2);
		send_run(1'b0, 1);
		// Poll step lowered below the phase count in the middle of a hold.
		configure(20, 8, 0, 1);
		send_run(1'b1, 3);
		drain();
		set_reg(REG_POLL_STEP, 1);
		send_run(1'b1, 1);
		send_run(1'b0, 1);
		// Largest repeat total and interval; the sequence then runs into later phases.
		configure(1, 1, 65535, 65535);
		send_run(1'b1, 2);
		send_run(1'b0, 1);
		configure(65535, 255, 65535, 65535);
		send_run(1'b1, 2);
		send_run(1'b0, 1);
	endtask

	// Mostly whole presses of random length, some with a glitch in the hold,
	// mixed with runs of random levels.
	task automatic random_presses(input int count);
		int stop, span, eff_poll, hold_len, glitch;
		stop = ticks_sent + count;
		while (ticks_sent < stop) begin
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(0, 1)));
			end else begin
				eff_poll = (cfg_poll == 8'd0) ? 1 : cfg_poll;
				span = cfg_lpt + 2 * eff_poll + 2;
				if (span > 80)
					span = 80;
				hold_len = $urandom_range(1, span);
				glitch = ($urandom_range(0, 3) == 0) ? $urandom_range(0, hold_len - 1) : -1;
				for (int i = 0; i < hold_len; i++)
					send_tick(i != glitch);
				if ($urandom_range(0, 3) == 0)
					send_run(1'b0, $urandom_range(13, 40));
				else
					send_run(1'b0, $urandom_range(1, 12));
			end
		end
	endtask

	task automatic test_random();
		int lpt, poll, total, interval, pick;
		for (int ph = 0; ph < 12; ph++) begin
			pick = $urandom_range(0, 9);
			lpt = (pick == 0) ? 0 : (pick == 1) ? 65535 : $urandom_range(1, 24);
			pick = $urandom_range(0, 9);
			poll = (pick == 0) ? 0 : (pick == 1) ? 255 : $urandom_range(1, 5);
			pick = $urandom_range(0, 9);
			total = (pick == 0) ? 65535 : (pick < 3) ? 0 : $urandom_range(1, 5);
			pick = $urandom_range(0, 9);
			interval = (pick == 0) ? 0 : (pick == 1) ? 65535 : $urandom_range(1, 6);
			configure(lpt, poll, total, interval);
			no_idle = ($urandom_range(0, 3) == 0);
			random_presses(90);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_long_and_repeat();
		test_repeat_totals();
		no_idle = 1'b1;
		test_special_cases();
		no_idle = 1'b0;
		test_random();
		drain();
		repeat (4) @(posedge clk);
		if (expected_events.size() != 0)
			report_mismatch("events never produced", expected_events.size(), 0);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire
